[hw/rtl/wpp_pkg.sv]
package wpp_pkg;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_TAG   = 3'd1;
    localparam logic [2:0] ST_BAD_SYNC  = 3'd2;
    localparam logic [2:0] ST_BAD_SIG   = 3'd3;
    localparam logic [2:0] ST_BAD_CHUNK = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;

    localparam logic [1:0] FMT_LOSSY    = 2'd0;
    localparam logic [1:0] FMT_LOSSLESS = 2'd1;
    localparam logic [1:0] FMT_EXTENDED = 2'd2;

    localparam logic [7:0] TAG_RIFF [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
    localparam logic [7:0] TAG_WEBP [4] = '{8'h57, 8'h45, 8'h42, 8'h50};
    localparam logic [7:0] TAG_VP8  [3] = '{8'h56, 8'h50, 8'h38};
    localparam logic [7:0] FRAME_START [3] = '{8'h9D, 8'h01, 8'h2A};

    localparam logic [7:0] KIND_LOSSY    = 8'h20;
    localparam logic [7:0] KIND_LOSSLESS = 8'h4C;
    localparam logic [7:0] KIND_EXTENDED = 8'h58;
    localparam logic [7:0] LOSSLESS_SIG  = 8'h2F;

    localparam int unsigned ALPHA_LAYOUT_BIT = 4;

    localparam logic [4:0] POS_RIFF_END  = 5'd4;
    localparam logic [4:0] POS_WEBP      = 5'd8;
    localparam logic [4:0] POS_WEBP_END  = 5'd12;
    localparam logic [4:0] POS_KIND      = 5'd15;
    localparam logic [4:0] POS_PAYLOAD   = 5'd20;
    localparam logic [4:0] POS_SYNC      = 5'd23;
    localparam logic [4:0] POS_SYNC_LAST = 5'd25;
    localparam logic [4:0] POS_VP8_WIDTH = 5'd27;
    localparam logic [4:0] POS_VP8_HEIGHT = 5'd29;
    localparam logic [4:0] POS_VP8L_WORD = 5'd24;
    localparam logic [4:0] POS_VP8X_WIDTH = 5'd26;
    localparam logic [4:0] POS_VP8X_HEIGHT = 5'd29;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  format;
        logic [24:0] image_width;
        logic [24:0] image_height;
        logic        has_alpha;
        logic [2:0]  channel_count;
    } result_t;

endpackage

[hw/rtl/webp_header_parser_top.sv]
// WebP header parser. Feed the file one byte per word with end_of_stream on the
// last byte; the block returns one word per file with status, format, image size,
// alpha flag and channel count, and drops the remaining bytes of that file. It takes
// one byte every cycle while in_stall is low; the deciding byte is held in the input
// register, the per-byte tag compare and shift run on it combinationally, and its
// result is loaded into the result register. A result held by out_stall stalls
// input only when the next byte would also produce a result.
module webp_header_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [1:0]  format,
    output logic [24:0] image_width,
    output logic [24:0] image_height,
    output logic        has_alpha,
    output logic [2:0]  channel_count
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       byte_reg;
    logic             eos_reg;
    logic             out_valid_reg, out_valid_next;
    wpp_pkg::result_t result_reg;
    wpp_pkg::result_t core_result;
    logic             core_emit;
    logic             advance;
    logic             accept;

    wpp_parse_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .data_byte     (byte_reg),
        .end_of_stream (eos_reg),
        .emit          (core_emit),
        .result        (core_result)
    );

    assign advance  = in_valid_reg && (!core_emit || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && core_emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
            eos_reg  <= end_of_stream;
        end
        if (advance && core_emit)
            result_reg <= core_result;
    end

    assign out_valid     = out_valid_reg;
    assign status        = result_reg.status;
    assign format        = result_reg.format;
    assign image_width   = result_reg.image_width;
    assign image_height  = result_reg.image_height;
    assign has_alpha     = result_reg.has_alpha;
    assign channel_count = result_reg.channel_count;

endmodule

[hw/rtl/wpp_parse_core.sv]
module wpp_parse_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             end_of_stream,
    output logic             emit,
    output wpp_pkg::result_t result
);

    logic [4:0]  pos_reg, pos_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [31:0] shift_reg, shift_next;
    logic [24:0] width_reg, width_next;
    logic        alpha_reg, alpha_next;
    logic        decided_reg, decided_next;

    logic [31:0] shift_new;
    logic [4:0]  sync_idx;
    logic        found;
    logic [2:0]  st;
    logic [24:0] height;
    logic [1:0]  fmt_upd;
    logic [24:0] width_upd;
    logic        alpha_upd;

    assign shift_new = {data_byte, shift_reg[31:8]};
    assign sync_idx  = pos_reg - wpp_pkg::POS_SYNC;

    always_comb
    begin
        found     = 1'b0;
        st        = wpp_pkg::ST_OK;
        height    = '0;
        fmt_upd   = fmt_reg;
        width_upd = width_reg;
        alpha_upd = alpha_reg;
        if (pos_reg < wpp_pkg::POS_RIFF_END)
        begin
            if (data_byte != wpp_pkg::TAG_RIFF[pos_reg[1:0]])
            begin
                found = 1'b1;
                st    = wpp_pkg::ST_BAD_TAG;
            end
        end
        else if (pos_reg >= wpp_pkg::POS_WEBP && pos_reg < wpp_pkg::POS_WEBP_END)
        begin
            if (data_byte != wpp_pkg::TAG_WEBP[pos_reg[1:0]])
            begin
                found = 1'b1;
                st    = wpp_pkg::ST_BAD_TAG;
            end
        end
        else if (pos_reg >= wpp_pkg::POS_WEBP_END && pos_reg < wpp_pkg::POS_KIND)
        begin
            if (data_byte != wpp_pkg::TAG_VP8[pos_reg[1:0]])
            begin
                found = 1'b1;
                st    = wpp_pkg::ST_BAD_CHUNK;
            end
        end
        else if (pos_reg == wpp_pkg::POS_KIND)
        begin
            if (data_byte == wpp_pkg::KIND_LOSSY)
                fmt_upd = wpp_pkg::FMT_LOSSY;
            else if (data_byte == wpp_pkg::KIND_LOSSLESS)
                fmt_upd = wpp_pkg::FMT_LOSSLESS;
            else if (data_byte == wpp_pkg::KIND_EXTENDED)
                fmt_upd = wpp_pkg::FMT_EXTENDED;
            else
            begin
                found = 1'b1;
                st    = wpp_pkg::ST_BAD_CHUNK;
            end
        end
        else if (pos_reg >= wpp_pkg::POS_PAYLOAD)
        begin
            case (fmt_reg)
                wpp_pkg::FMT_LOSSY:
                begin
                    if (pos_reg >= wpp_pkg::POS_SYNC && pos_reg <= wpp_pkg::POS_SYNC_LAST)
                    begin
                        if (data_byte != wpp_pkg::FRAME_START[sync_idx[1:0]])
                        begin
                            found = 1'b1;
                            st    = wpp_pkg::ST_BAD_SYNC;
                        end
                    end
                    else if (pos_reg == wpp_pkg::POS_VP8_WIDTH)
                        width_upd = {11'd0, shift_new[29:16]};
                    else if (pos_reg == wpp_pkg::POS_VP8_HEIGHT)
                    begin
                        height = {11'd0, shift_new[29:16]};
                        found  = 1'b1;
                    end
                end
                wpp_pkg::FMT_LOSSLESS:
                begin
                    if (pos_reg == wpp_pkg::POS_PAYLOAD)
                    begin
                        if (data_byte != wpp_pkg::LOSSLESS_SIG)
                        begin
                            found = 1'b1;
                            st    = wpp_pkg::ST_BAD_SIG;
                        end
                    end
                    else if (pos_reg == wpp_pkg::POS_VP8L_WORD)
                    begin
                        width_upd = {11'd0, shift_new[13:0]} + 25'd1;
                        height    = {11'd0, shift_new[27:14]} + 25'd1;
                        alpha_upd = shift_new[28];
                        found     = 1'b1;
                    end
                end
                wpp_pkg::FMT_EXTENDED:
                begin
                    if (pos_reg == wpp_pkg::POS_PAYLOAD)
                        alpha_upd = data_byte[wpp_pkg::ALPHA_LAYOUT_BIT];
                    else if (pos_reg == wpp_pkg::POS_VP8X_WIDTH)
                        width_upd = {1'b0, shift_new[31:8]} + 25'd1;
                    else if (pos_reg == wpp_pkg::POS_VP8X_HEIGHT)
                    begin
                        height = {1'b0, shift_new[31:8]} + 25'd1;
                        found  = 1'b1;
                    end
                end
                default:
                begin
                    found = 1'b1;
                    st    = wpp_pkg::ST_BAD_CHUNK;
                end
            endcase
        end
    end

    always_comb
    begin
        emit   = 1'b0;
        result = '0;
        result.channel_count = 3'd3;
        if (!decided_reg)
        begin
            if (found)
            begin
                emit          = 1'b1;
                result.status = st;
                if (st == wpp_pkg::ST_OK)
                begin
                    result.format        = fmt_upd;
                    result.image_width   = width_upd;
                    result.image_height  = height;
                    result.has_alpha     = alpha_upd;
                    result.channel_count = 3'd3 + {2'd0, alpha_upd};
                end
            end
            else if (end_of_stream)
            begin
                emit          = 1'b1;
                result.status = wpp_pkg::ST_TRUNC;
            end
        end
    end

    always_comb
    begin
        pos_next     = pos_reg;
        fmt_next     = fmt_reg;
        shift_next   = shift_reg;
        width_next   = width_reg;
        alpha_next   = alpha_reg;
        decided_next = decided_reg;
        if (step)
        begin
            if (end_of_stream)
            begin
                pos_next     = '0;
                fmt_next     = '0;
                shift_next   = '0;
                width_next   = '0;
                alpha_next   = 1'b0;
                decided_next = 1'b0;
            end
            else if (!decided_reg)
            begin
                pos_next     = pos_reg + 5'd1;
                fmt_next     = fmt_upd;
                shift_next   = shift_new;
                width_next   = width_upd;
                alpha_next   = alpha_upd;
                decided_next = found;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            fmt_reg     <= '0;
            shift_reg   <= '0;
            width_reg   <= '0;
            alpha_reg   <= 1'b0;
            decided_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            fmt_reg     <= fmt_next;
            shift_reg   <= shift_next;
            width_reg   <= width_next;
            alpha_reg   <= alpha_next;
            decided_reg <= decided_next;
        end
    end

endmodule
